>>> src/escaped_packet_deframer_top_macros.svh
// Assertion macros for the packet deframer.
`ifndef ESCAPED_PACKET_DEFRAMER_TOP_MACROS_SVH
`define ESCAPED_PACKET_DEFRAMER_TOP_MACROS_SVH

`ifndef SYNTH
// Checked only while the block is out of reset.
`define EPD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every edge, reset included.
`define EPD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EPD_ASSERT(lbl, clk, rst, prop, msg)
`define EPD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> src/epd_pkg.sv
`default_nettype none

package epd_pkg;

  localparam int BODY_LEN    = 10;
  localparam int PAYLOAD_LEN = 8;
  localparam int COUNT_W     = 4;
  localparam int PID_IDX     = 0;
  localparam int ESC_IDX     = 9;

  localparam logic [7:0] FRAME_MARK   = 8'hFF;
  localparam logic [7:0] ALL_ESC_MARK = 8'hA5;
  localparam logic [COUNT_W-1:0] LAST_BODY = COUNT_W'(BODY_LEN - 1);
  localparam logic [COUNT_W-1:0] FULL_BODY = COUNT_W'(BODY_LEN);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_COLLECT = 2'd1,
    PH_CLOSE   = 2'd2
  } phase_t;

  typedef logic [BODY_LEN-1:0][7:0] body_t;

  typedef struct packed {
    phase_t              phase;
    logic [COUNT_W-1:0]  count;
    logic                close_hit;
  } ctrl_status_t;

  typedef struct packed {
    logic                         pid_ok;
    logic [3:0]                   packet_id;
    logic [PAYLOAD_LEN-1:0][7:0]  payload;
  } result_t;

endpackage

`default_nettype wire

>>> src/epd_frame_ctrl.sv
`default_nettype none

module epd_frame_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire logic [7:0]            rx_byte,
  output epd_pkg::body_t             body,
  output epd_pkg::ctrl_status_t      status
);
  import epd_pkg::*;

  phase_t             phase;
  phase_t             phase_next;
  logic [COUNT_W-1:0] count;
  body_t              store;
  logic               is_mark;
  logic               count_clr;
  logic               store_wr;
  logic               close_hit;

  assign is_mark = (rx_byte == FRAME_MARK);

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE: begin
        if (accept && is_mark) phase_next = PH_COLLECT;
      end
      PH_COLLECT: begin
        if (accept) begin
          if (is_mark) begin
            if (count != '0) phase_next = PH_IDLE;
          end else if (count == LAST_BODY) begin
            phase_next = PH_CLOSE;
          end
        end
      end
      PH_CLOSE: begin
        if (accept) phase_next = PH_IDLE;
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_comb begin
    count_clr = 1'b0;
    store_wr  = 1'b0;
    close_hit = 1'b0;
    unique case (phase)
      PH_COLLECT: begin
        count_clr = accept && is_mark && (count != '0);
        store_wr  = accept && !is_mark && (count < FULL_BODY);
      end
      PH_CLOSE: begin
        count_clr = accept && !is_mark;
        close_hit = accept && is_mark;
      end
      default: begin
        count_clr = accept && is_mark;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      count <= '0;
    end else begin
      phase <= phase_next;
      if (count_clr) begin
        count <= '0;
      end else if (store_wr) begin
        count <= count + 1'b1;
      end
    end
  end

  // The body is only read after all ten entries of the current packet are written.
  always_ff @(posedge clk) begin
    if (store_wr) store[count] <= rx_byte;
  end

  assign body             = store;
  assign status.phase     = phase;
  assign status.count     = count;
  assign status.close_hit = close_hit;

endmodule

`default_nettype wire

>>> src/epd_unescape.sv
`default_nettype none

module epd_unescape (
  input  wire epd_pkg::body_t body,
  output epd_pkg::result_t    result
);
  import epd_pkg::*;

  logic [7:0] pid;
  logic [7:0] esc;
  logic       all_esc;

  assign pid     = body[PID_IDX];
  assign esc     = body[ESC_IDX];
  assign all_esc = (body[1] == ALL_ESC_MARK) && (esc == ALL_ESC_MARK);

  always_comb begin
    result.pid_ok    = (pid[7:4] == ~pid[3:0]);
    result.packet_id = pid[7:4];
    for (int i = 0; i < PAYLOAD_LEN; i++) begin
      result.payload[i] = (all_esc || esc[i]) ? FRAME_MARK : body[i + 1];
    end
  end

endmodule

`default_nettype wire

>>> src/epd_result_reg.sv
`default_nettype none

module epd_result_reg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          load,
  input  wire epd_pkg::result_t              result,
  output logic                               free,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [3:0]                         packet_id,
  output logic [epd_pkg::PAYLOAD_LEN-1:0][7:0] payload
);
  import epd_pkg::*;

  // The slot can take a new result in the same cycle the old one transfers.
  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      packet_id <= result.packet_id;
      payload   <= result.payload;
    end
  end

endmodule

`default_nettype wire

>>> src/escaped_packet_deframer_top.sv
// Takes one byte per cycle while in_ready is high; a good packet's result appears in the cycle after its closing 0xFF.
// Throughput: one byte per cycle while the single result register is free; that register accepts
// a new result in the cycle the previous one transfers.
// Reset (synchronous, active high) returns the framer to idle, clears the body count
// and empties the result register; the body store itself is not cleared.
`default_nettype none

`include "escaped_packet_deframer_top_macros.svh"

module escaped_packet_deframer_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [3:0]      packet_id,
  output logic [7:0]      payload_0,
  output logic [7:0]      payload_1,
  output logic [7:0]      payload_2,
  output logic [7:0]      payload_3,
  output logic [7:0]      payload_4,
  output logic [7:0]      payload_5,
  output logic [7:0]      payload_6,
  output logic [7:0]      payload_7
);
  import epd_pkg::*;

  logic                         accept;
  logic                         free;
  logic                         load;
  body_t                        body;
  ctrl_status_t                 status;
  result_t                      result;
  logic [PAYLOAD_LEN-1:0][7:0]  payload;

  assign in_ready = free;
  assign accept   = in_valid && free;
  assign load     = status.close_hit && result.pid_ok;

  epd_frame_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .body    (body),
    .status  (status)
  );

  epd_unescape u_unescape (
    .body   (body),
    .result (result)
  );

  epd_result_reg u_result (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .result    (result),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .packet_id (packet_id),
    .payload   (payload)
  );

  assign payload_0 = payload[0];
  assign payload_1 = payload[1];
  assign payload_2 = payload[2];
  assign payload_3 = payload[3];
  assign payload_4 = payload[4];
  assign payload_5 = payload[5];
  assign payload_6 = payload[6];
  assign payload_7 = payload[7];

  `EPD_ASSERT(a_close_full, clk, rst, (status.phase == PH_CLOSE) |-> (status.count == FULL_BODY), "awaiting close without a full body")
  `EPD_ASSERT(a_collect_range, clk, rst, (status.phase == PH_COLLECT) |-> (status.count < FULL_BODY), "body count out of range while collecting")
  `EPD_ASSERT(a_result_source, clk, rst, $rose(out_valid) |-> $past(load), "result appeared without a good close")
  `EPD_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> !out_valid, "result register not empty after reset")

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import epd_pkg::*;

  localparam int RANDOM_BYTES    = 1600;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 20;

  typedef struct packed {
    logic [3:0]                  pid;
    logic [PAYLOAD_LEN-1:0][7:0] bytes;
  } deframed_t;

  class deframe_scoreboard;
    phase_t     phase;
    logic [3:0] body_cnt;
    logic [7:0] body [BODY_LEN];
    deframed_t  expected_q [$];
    int         mismatches;

    function new();
      phase      = PH_IDLE;
      body_cnt   = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
    endfunction

    // Advances the framing state by one byte and queues a completed packet whose identifier checks.
    function void take_rx_byte(logic [7:0] b);
      deframed_t  pkt;
      logic [7:0] pid;
      logic [7:0] esc;
      logic       all_esc;
      case (phase)
        PH_COLLECT: begin
          if (b == FRAME_MARK) begin
            if (body_cnt != '0) begin
              phase    = PH_IDLE;
              body_cnt = '0;
            end
          end else if (body_cnt < FULL_BODY) begin
            body[body_cnt] = b;
            body_cnt = body_cnt + 1'b1;
            if (body_cnt == FULL_BODY) phase = PH_CLOSE;
          end
        end
        PH_CLOSE: begin
          phase = PH_IDLE;
          if (b != FRAME_MARK) begin
            body_cnt = '0;
          end else begin
            pid = body[PID_IDX];
            esc = body[ESC_IDX];
            if (pid[7:4] == ~pid[3:0]) begin
              all_esc = (body[PID_IDX + 1] == ALL_ESC_MARK) && (esc == ALL_ESC_MARK);
              pkt.pid = pid[7:4];
              for (int i = 0; i < PAYLOAD_LEN; i++)
                pkt.bytes[i] = (all_esc || esc[i]) ? FRAME_MARK : body[PID_IDX + 1 + i];
              expected_q.push_back(pkt);
            end
          end
        end
        default: begin
          if (b == FRAME_MARK) begin
            phase    = PH_COLLECT;
            body_cnt = '0;
          end else begin
            phase = PH_IDLE;
          end
        end
      endcase
    endfunction

    function void check_packet(deframed_t got);
      deframed_t want;
      if (expected_q.size() == 0) begin
        note_mismatch($sformatf("packet with packet_id %0h arrived, none expected", got.pid));
        return;
      end
      want = expected_q.pop_front();
      if (got.pid !== want.pid)
        note_mismatch($sformatf("packet_id expected %0h, got %0h", want.pid, got.pid));
      for (int i = 0; i < PAYLOAD_LEN; i++)
        if (got.bytes[i] !== want.bytes[i])
          note_mismatch($sformatf("payload_%0d expected %02h, got %02h",
                                  i, want.bytes[i], got.bytes[i]));
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [3:0] packet_id;
  logic [7:0] payload_0;
  logic [7:0] payload_1;
  logic [7:0] payload_2;
  logic [7:0] payload_3;
  logic [7:0] payload_4;
  logic [7:0] payload_5;
  logic [7:0] payload_6;
  logic [7:0] payload_7;

  deframe_scoreboard sb = new();

  int bytes_sent;
  int quiet_cycles;
  int hold_left;
  bit sender_steady;
  bit receiver_steady;

  escaped_packet_deframer_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .packet_id (packet_id),
    .payload_0 (payload_0),
    .payload_1 (payload_1),
    .payload_2 (payload_2),
    .payload_3 (payload_3),
    .payload_4 (payload_4),
    .payload_5 (payload_5),
    .payload_6 (payload_6),
    .payload_7 (payload_7)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Receiver side: random back-pressure (none while steady), plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= receiver_steady || ($urandom_range(99) >= 25);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (in_valid && in_ready) sb.take_rx_byte(rx_byte);
      if (out_valid && out_ready)
        sb.check_packet({packet_id, payload_7, payload_6, payload_5, payload_4,
                         payload_3, payload_2, payload_1, payload_0});
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (!sender_steady)
      while ($urandom_range(99) < 25) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  initial begin
    logic [7:0] opening [$];
    logic [7:0] seq [$];
    logic [7:0] body [BODY_LEN];
    logic [3:0] hi;
    int         pick;
    int         cut;
    bit         hold_done;
    bit         pause_done;

    rst             = 1'b1;
    in_valid        = 1'b0;
    rx_byte         = '0;
    out_ready       = 1'b0;
    hold_left       = 0;
    bytes_sent      = 0;
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;
    hold_done       = 1'b0;
    pause_done      = 1'b0;

    // Idle noise, a doubled start before an all-escape packet, a packet with
    // identifier 0xF and a partial mask, then an early mark abort.
    opening = '{8'h00, 8'h7F,
                FRAME_MARK, FRAME_MARK, 8'h0F, ALL_ESC_MARK, 8'h00, 8'hFE, 8'h01,
                8'h80, 8'h55, 8'hAA, 8'h7E, ALL_ESC_MARK, FRAME_MARK,
                FRAME_MARK, 8'hF0, 8'hFE, 8'h00, 8'h01, 8'h02, 8'h04, 8'h08,
                8'h10, 8'h20, 8'h0F, FRAME_MARK,
                FRAME_MARK, 8'hF0, FRAME_MARK};

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (opening[i]) send_byte(opening[i]);

    while (bytes_sent < opening.size() + RANDOM_BYTES) begin
      if (!hold_done && bytes_sent >= 400) begin
        hold_done = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (!pause_done && bytes_sent >= 800) begin
        pause_done = 1'b1;
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0) @(negedge clk);
      end
      sender_steady   = (bytes_sent >= 1000) && (bytes_sent < 1300);
      receiver_steady = sender_steady;

      // Body bytes never carry the mark value; a mark inside a packet is an abort.
      hi = 4'($urandom_range(15));
      if ($urandom_range(9) == 0) begin
        do body[PID_IDX] = 8'($urandom_range(254));
        while (body[PID_IDX][7:4] == ~body[PID_IDX][3:0]);
      end else begin
        body[PID_IDX] = {hi, ~hi};
      end
      for (int i = 1; i <= PAYLOAD_LEN; i++)
        case ($urandom_range(7))
          0:       body[i] = 8'h00;
          1:       body[i] = 8'hFE;
          default: body[i] = 8'($urandom_range(254));
        endcase
      case ($urandom_range(5))
        0: body[ESC_IDX] = 8'h00;
        1: begin
          body[PID_IDX + 1] = ALL_ESC_MARK;
          body[ESC_IDX]     = ALL_ESC_MARK;
        end
        2: body[ESC_IDX] = ALL_ESC_MARK;
        3: begin
          body[PID_IDX + 1] = ALL_ESC_MARK;
          body[ESC_IDX]     = 8'($urandom_range(254));
        end
        default: body[ESC_IDX] = 8'($urandom_range(254));
      endcase

      seq.delete();
      pick = $urandom_range(99);
      if (pick < 12) begin
        repeat ($urandom_range(5, 1)) seq.push_back(8'($urandom_range(255)));
      end else begin
        seq.push_back(FRAME_MARK);
        if ($urandom_range(9) == 0) seq.push_back(FRAME_MARK);
        cut = (pick < 20) ? $urandom_range(BODY_LEN - 1, 1) : BODY_LEN;
        for (int i = 0; i < cut; i++) seq.push_back(body[i]);
        if (pick >= 20 && pick < 26) seq.push_back(8'($urandom_range(254)));
        else seq.push_back(FRAME_MARK);
      end
      foreach (seq[i]) send_byte(seq[i]);
    end

    sender_steady = 1'b0;
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
